// ----- sv/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, widths and codes of the crossfading feedback delay.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CHANNELS    = 2;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DELAY_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int MEM_AW      = CH_W + ADDR_W;

    localparam int DLY_W  = 16;
    localparam int GAIN_W = 16;
    localparam int STEP_W = 17;
    localparam int POS_W  = 17;
    localparam int RAMP_W = 18;
    localparam int CFG_W  = 17;
    localparam int CIDX_W = 2;

    localparam logic [POS_W-1:0] FADE_ONE   = POS_W'(65536);
    localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(6554);

    // register indexes of the configuration port
    localparam logic [CIDX_W-1:0] CFG_TARGET_DELAY  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FADE_STEP     = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_RB,
        ST_RA,
        ST_MIX
    } state_t;

    // fade part of one channel's state
    typedef struct packed {
        logic signed [RAMP_W-1:0] ramp;
        logic [POS_W-1:0]         pos;
        logic [DLY_W-1:0]         tap_a;
        logic [DLY_W-1:0]         tap_b;
    } fade_state_t;

endpackage

// ----- sv/cfd_ram.sv -----
// ----------------------------------------------------------------------------
// cfd_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module cfd_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 17
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/cfd_fade.sv -----
// ----------------------------------------------------------------------------
// cfd_fade
// Crossfade control: ramp decision, clamped fade position and tap swap.
// ----------------------------------------------------------------------------
module cfd_fade (
    input  cfd_pkg::fade_state_t         cur,
    input  logic [cfd_pkg::DLY_W-1:0]    target_delay,
    input  logic [cfd_pkg::STEP_W-1:0]   fade_step,
    output cfd_pkg::fade_state_t         nxt
);
    import cfd_pkg::*;

    logic signed [RAMP_W-1:0] step_s;
    logic signed [RAMP_W-1:0] rr;
    logic signed [POS_W+1:0]  pos_sum;
    logic                     at_zero;
    logic                     at_one;

    assign step_s  = $signed({1'b0, fade_step});
    assign at_zero = (cur.pos == '0);
    assign at_one  = (cur.pos >= FADE_ONE);

    always_comb
    begin
        if (cur.ramp != '0)
            rr = (!at_zero && !at_one) ? cur.ramp : '0;
        else if (at_zero && target_delay != cur.tap_a)
            rr = step_s;
        else if (at_one && target_delay != cur.tap_b)
            rr = -step_s;
        else
            rr = '0;
    end

    assign pos_sum = $signed({2'b00, cur.pos}) + $signed({rr[RAMP_W-1], rr});

    always_comb
    begin
        nxt.ramp = rr;
        if (pos_sum < 0)
            nxt.pos = '0;
        else if (pos_sum > $signed({2'b00, FADE_ONE}))
            nxt.pos = FADE_ONE;
        else
            nxt.pos = pos_sum[POS_W-1:0];
        // the arriving tap picks up the new delay as the fade leaves its end
        nxt.tap_a = (at_one && cur.tap_b != target_delay) ? target_delay : cur.tap_a;
        nxt.tap_b = (at_zero && cur.tap_a != target_delay) ? target_delay : cur.tap_b;
    end

endmodule

// ----- sv/crossfading_feedback_delay.sv -----
// ----------------------------------------------------------------------------
// crossfading_feedback_delay
// Two-channel feedback delay line with click-free delay changes by crossfade.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tdata = sample_in (24-bit signed), tuser = chan.
//   Output stream m_*: tdata = sample_out (24-bit signed), tuser = chan_out.
//   One result per request, in request order.
//   Config port: cfg_we / cfg_index / cfg_data, written only while idle:
//   0 target_delay, 1 feedback_gain (Q1.15), 2 fade_step (Q1.16).
//   Each request runs through the sequencer steps write, read tap B, read
//   tap A and mix: one buffer write of input plus feedback and two tap reads
//   through the single port of the delay buffer RAM, then the mix. The mix
//   of one request can go straight on to the write of the next.
//   A one-entry input holding register takes the next request while the
//   current one is in work; the output register holds a result while the
//   receiver stalls, and the sequencer waits in its mix step until it drains.
//   Reset clears channel state, configuration and control registers; the
//   buffer itself is not cleared: per channel a wrap flag and the write index
//   mark which entries were written, and an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module crossfading_feedback_delay (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // [23:0] sample_in
    input  logic                         s_tuser,   // [0] chan
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [23:0] sample_out
    output logic                         m_tuser,   // [0] chan_out
    input  logic                         cfg_we,
    input  logic [cfd_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [cfd_pkg::CFG_W-1:0]    cfg_data
);
    import cfd_pkg::*;

    // configuration
    logic [DLY_W-1:0]  target_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [STEP_W-1:0] step_reg;

    // per-channel state
    sample_t           last_arr   [CHANNELS];
    fade_state_t       fade_arr   [CHANNELS];
    logic [ADDR_W-1:0] widx_arr   [CHANNELS];
    logic              wrap_arr   [CHANNELS];

    // sequencer
    state_t state_reg, state_next;
    logic   start, finish;
    logic   in_acc;

    logic             pend_valid_reg, pend_valid_next;
    logic [CH_W-1:0]  pend_chan_reg;
    sample_t          pend_sample_reg;
    logic [CH_W-1:0]  work_chan_reg;
    sample_t          work_sample_reg;

    logic [ADDR_W-1:0] addr_a_reg, addr_b_reg;
    logic              valid_a_reg, valid_b_reg;
    logic [POS_W-1:0]  pos_reg;
    sample_t           tb_reg;

    logic             out_valid_reg, out_valid_next;
    logic             out_chan_reg;
    sample_t          out_sample_reg;

    // memory port
    logic              mem_en, mem_we;
    logic [MEM_AW-1:0] mem_addr;
    sample_t           mem_wdata;
    logic [SAMPLE_BITS-1:0] mem_rdata;

    // write-step datapath
    fade_state_t             cur_fade, nxt_fade;
    logic [ADDR_W-1:0]       w_cur;
    logic signed [GAIN_W+SAMPLE_BITS:0]   fb_prod;
    logic signed [GAIN_W+SAMPLE_BITS+1:0] fb_round;
    logic signed [SAMPLE_BITS+2:0]        fb_val;
    logic signed [SAMPLE_BITS+3:0]        wsum;
    logic [ADDR_W-1:0]       idx_a, idx_b;

    // mix datapath
    sample_t                          ta;
    logic signed [SAMPLE_BITS:0]      tdiff;
    logic signed [POS_W+SAMPLE_BITS+1:0] mix_prod;
    logic signed [POS_W+SAMPLE_BITS+1:0] mix_acc;
    sample_t                          mix;

    localparam logic signed [SAMPLE_BITS+3:0] SMAX =
        (SAMPLE_BITS+4)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [SAMPLE_BITS+3:0] SMIN = -SMAX - (SAMPLE_BITS+4)'(1);

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = !pend_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_chan_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gain_reg   <= '0;
            step_reg   <= STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_DELAY:  target_reg <= cfg_data[DLY_W-1:0];
                CFG_FEEDBACK_GAIN: gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_FADE_STEP:     step_reg   <= cfg_data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign finish = (state_reg == ST_MIX) && (!out_valid_reg || m_tready);
    assign start  = pend_valid_reg && ((state_reg == ST_IDLE) || finish);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_WR;
            ST_WR:   state_next = ST_RB;
            ST_RB:   state_next = ST_RA;
            ST_RA:   state_next = ST_MIX;
            ST_MIX:
            begin
                if (finish)
                    state_next = start ? ST_WR : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory access per step: write, read tap B, read tap A
    always_comb
    begin
        mem_en   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = {work_chan_reg, w_cur};
        case (state_reg)
            ST_WR:
            begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = {work_chan_reg, w_cur};
            end
            ST_RB:
            begin
                mem_en   = 1'b1;
                mem_addr = {work_chan_reg, addr_b_reg};
            end
            ST_RA:
            begin
                mem_en   = 1'b1;
                mem_addr = {work_chan_reg, addr_a_reg};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (in_acc)
            pend_valid_next = 1'b1;
        else if (start)
            pend_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ---------------- write step ----------------
    assign cur_fade = fade_arr[work_chan_reg];
    assign w_cur    = widx_arr[work_chan_reg];

    cfd_fade u_fade (
        .cur          (cur_fade),
        .target_delay (target_reg),
        .fade_step    (step_reg),
        .nxt          (nxt_fade)
    );

    assign fb_prod  = $signed({1'b0, gain_reg}) * last_arr[work_chan_reg];
    assign fb_round = (GAIN_W+SAMPLE_BITS+2)'(fb_prod) + (GAIN_W+SAMPLE_BITS+2)'(16384);
    assign fb_val   = fb_round[GAIN_W+SAMPLE_BITS+1:15];
    assign wsum     = (SAMPLE_BITS+4)'(work_sample_reg) + (SAMPLE_BITS+4)'(fb_val);

    always_comb
    begin
        if (wsum > SMAX)
            mem_wdata = SMAX[SAMPLE_BITS-1:0];
        else if (wsum < SMIN)
            mem_wdata = SMIN[SAMPLE_BITS-1:0];
        else
            mem_wdata = wsum[SAMPLE_BITS-1:0];
    end

    assign idx_a = w_cur - nxt_fade.tap_a[ADDR_W-1:0];
    assign idx_b = w_cur - nxt_fade.tap_b[ADDR_W-1:0];

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_arr[i] <= '0;
                fade_arr[i] <= '0;
                widx_arr[i] <= '0;
                wrap_arr[i] <= 1'b0;
            end
        end
        else
        begin
            if (state_reg == ST_WR)
            begin
                fade_arr[work_chan_reg] <= nxt_fade;
                widx_arr[work_chan_reg] <= w_cur + ADDR_W'(1);
                if (w_cur == '1)
                    wrap_arr[work_chan_reg] <= 1'b1;
            end
            if (finish)
                last_arr[work_chan_reg] <= mix;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pend_chan_reg   <= s_tuser;
            pend_sample_reg <= s_tdata;
        end
        if (start)
        begin
            work_chan_reg   <= pend_chan_reg;
            work_sample_reg <= pend_sample_reg;
        end
        if (state_reg == ST_WR)
        begin
            addr_a_reg  <= idx_a;
            addr_b_reg  <= idx_b;
            // entries beyond the write index of an unwrapped line are unwritten
            valid_a_reg <= wrap_arr[work_chan_reg] || (idx_a <= w_cur);
            valid_b_reg <= wrap_arr[work_chan_reg] || (idx_b <= w_cur);
            pos_reg     <= nxt_fade.pos;
        end
        if (state_reg == ST_RA)
            tb_reg <= valid_b_reg ? mem_rdata : '0;
        if (finish)
        begin
            out_chan_reg   <= work_chan_reg;
            out_sample_reg <= mix;
        end
    end

    cfd_ram #(
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (MEM_AW)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // ---------------- mix ----------------
    // pos*tb + (1-pos)*ta == ta*2^16 + pos*(tb - ta)
    assign ta       = valid_a_reg ? mem_rdata : '0;
    assign tdiff    = (SAMPLE_BITS+1)'(tb_reg) - (SAMPLE_BITS+1)'(ta);
    assign mix_prod = $signed({1'b0, pos_reg}) * tdiff;
    assign mix_acc  = mix_prod
                    + $signed({{(POS_W+2-16){ta[SAMPLE_BITS-1]}}, ta, 16'b0})
                    + (POS_W+SAMPLE_BITS+2)'(32768);
    assign mix      = mix_acc[SAMPLE_BITS+15:16];

endmodule

// ----- sv/cfd_checker.sv -----
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks of the crossfading feedback delay, bound to the top.
// ----------------------------------------------------------------------------
module cfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    logic [1:0] cnt_reg, cnt_next;
    logic       s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(s_acc) - 2'(m_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // no result without an outstanding request
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt_reg != 2'd0)
        else $error("result without request");

    // input back-pressure only while a request is in the block
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> cnt_reg != 2'd0)
        else $error("input stalled while empty");

    // idle block: result follows the request through write, both reads and mix
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && cnt_reg == 2'd0 |=>
            !m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid
            ##1 m_tvalid)
        else $error("wrong latency");

endmodule

bind crossfading_feedback_delay cfd_checker u_cfd_checker (.*);

// ----- tb/tb_crossfading_feedback_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crossfading_feedback_delay
// Self-checking bench for the two-channel crossfading feedback delay. A table
// of directed requests (extremes, every register, the unusual register values)
// runs first, then phases of random requests under varied idling and a long
// output stall. A behavioral delay line predicts every result in order.
// ----------------------------------------------------------------------------
module tb_crossfading_feedback_delay;
    import cfd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int LATENCY        = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 45;
    localparam int DIR_ROWS       = 32;

    // no register lives at this index; writes must be dropped
    localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam longint SMAX      = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMIN      = -SMAX - 1;
    localparam longint FADE_FULL = FADE_ONE;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CIDX_W-1:0]       idx;
        logic [CFG_W-1:0]        val;
        logic                    chan;
        logic [SAMPLE_BITS-1:0]  smp;
        logic                    chk;
        logic [SAMPLE_BITS-1:0]  want;
    } dir_row_t;

    typedef struct packed {
        logic                    chan;
        logic [SAMPLE_BITS-1:0]  smp;
    } out_item_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [SAMPLE_BITS-1:0]  s_tdata = '0;       // [23:0] sample_in
    logic                    s_tuser = 1'b0;     // [0] chan
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [SAMPLE_BITS-1:0]  m_tdata;            // [23:0] sample_out
    logic                    m_tuser;            // [0] chan_out
    logic                    cfg_we = 1'b0;
    logic [CIDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    crossfading_feedback_delay dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ---- delay line model ----
    logic [DLY_W-1:0]   tgt_delay;
    logic [GAIN_W-1:0]  gain_q15;
    logic [STEP_W-1:0]  step_q16;
    sample_t            last_out [CHANNELS];
    fade_state_t        fade     [CHANNELS];
    logic [ADDR_W-1:0]  wr_idx   [CHANNELS];
    sample_t            dly_mem  [CHANNELS][DELAY_DEPTH];

    out_item_t pending_out[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;

    function automatic sample_t sat_sample(input longint v);
        if (v > SMAX)
            return sample_t'(SMAX);
        if (v < SMIN)
            return sample_t'(SMIN);
        return sample_t'(v);
    endfunction

    task automatic delay_line_clear();
        tgt_delay = '0;
        gain_q15  = '0;
        step_q16  = STEP_RST;
        for (int c = 0; c < CHANNELS; c++)
        begin
            last_out[c] = '0;
            fade[c]     = '0;
            wr_idx[c]   = '0;
            for (int i = 0; i < DELAY_DEPTH; i++)
                dly_mem[c][i] = '0;
        end
    endtask

    task automatic delay_line_step(input logic chan, input sample_t x, output sample_t y);
        int                ch;
        logic [ADDR_W-1:0] w;
        logic [ADDR_W-1:0] a_idx;
        logic [ADDR_W-1:0] b_idx;
        logic [DLY_W-1:0]  a_nx;
        logic [DLY_W-1:0]  b_nx;
        fade_state_t       f;
        longint            fb;
        longint            pos;
        longint            rr;
        longint            pos_nx;
        longint            mix;
        ch = chan;
        w  = wr_idx[ch];
        f  = fade[ch];

        fb = (longint'(gain_q15) * longint'(last_out[ch]) + 16384) >>> 15;
        dly_mem[ch][w] = sat_sample(longint'(x) + fb);

        pos = f.pos;
        // a running ramp keeps going until it hits an end; an idle fade starts
        // only from an end whose active tap is off target
        if (f.ramp != 0)
            rr = (pos > 0 && pos < FADE_FULL) ? longint'(f.ramp) : 0;
        else if (pos == 0 && tgt_delay != f.tap_a)
            rr = step_q16;
        else if (pos == FADE_FULL && tgt_delay != f.tap_b)
            rr = -longint'(step_q16);
        else
            rr = 0;

        pos_nx = pos + rr;
        if (pos_nx < 0)
            pos_nx = 0;
        if (pos_nx > FADE_FULL)
            pos_nx = FADE_FULL;

        a_nx = (pos >= FADE_FULL && f.tap_b != tgt_delay) ? tgt_delay : f.tap_a;
        b_nx = (pos <= 0 && f.tap_a != tgt_delay) ? tgt_delay : f.tap_b;
        a_idx = w - a_nx;
        b_idx = w - b_nx;

        mix = (pos_nx * longint'(dly_mem[ch][b_idx])
               + (FADE_FULL - pos_nx) * longint'(dly_mem[ch][a_idx]) + 32768) >>> 16;
        y = sat_sample(mix);

        f.ramp  = RAMP_W'(rr);
        f.pos   = POS_W'(pos_nx);
        f.tap_a = a_nx;
        f.tap_b = b_nx;
        fade[ch]     = f;
        last_out[ch] = y;
        wr_idx[ch]   = w + 1'b1;
    endtask

    // ---- drivers ----
    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_TARGET_DELAY:  tgt_delay = val[DLY_W-1:0];
            CFG_FEEDBACK_GAIN: gain_q15  = val[GAIN_W-1:0];
            CFG_FADE_STEP:     step_q16  = val[STEP_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic chan, input sample_t x, input bit chk,
                               input sample_t want);
        sample_t   y;
        out_item_t e;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= chan;
        do @(posedge clk); while (!s_tready);
        delay_line_step(chan, x, y);
        e.chan = chan;
        e.smp  = chk ? want : y;
        pending_out.push_back(e);
    endtask

    // stop offering and let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(7))
            0:       return sample_t'(SMAX);
            1:       return sample_t'(SMIN);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input out_item_t want,
                                   input out_item_t got);
        $display("%0t ns  %s: expected ch%0d %h, got ch%0d %h",
                 $time, what, want.chan, want.smp, got.chan, got.smp);
        errors++;
    endtask

    // ---- receiver ----
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---- result check and watchdog ----
    always @(posedge clk)
    begin
        out_item_t seen;
        out_item_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.chan = m_tuser;
                seen.smp  = m_tdata;
                if (pending_out.size() == 0)
                    report_mismatch("result with no request pending", '0, seen);
                else
                begin
                    want = pending_out.pop_front();
                    if (seen.chan !== want.chan)
                        report_mismatch("chan_out", want, seen);
                    if (seen.smp !== want.smp)
                        report_mismatch("sample_out", want, seen);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---- directed requests ----
    dir_row_t dir_tab [DIR_ROWS] = '{
        // delay 0, gain 0: each sample comes straight back
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h800000, 1'b1, 24'h800000},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'h000000, 1'b1, 24'h000000},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h000001, 1'b1, 24'h000001},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h555555, 1'b1, 24'h555555},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'hAAAAAA, 1'b1, 24'hAAAAAA},
        // unity feedback, then gain above unity to hit the saturating sum
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 17'd32768, 1'b0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'h7FFFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'h7FFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 17'd65535, 1'b0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h7FFFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h800000, 1'b0, '0},
        '{ROW_CFG, CFG_UNMAPPED, 17'h1FFFF, 1'b0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 17'd0, 1'b0, '0, 1'b0, '0},
        // step past full scale: the fade jumps end to end in one sample
        '{ROW_CFG, CFG_FADE_STEP, 17'd131071, 1'b0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_TARGET_DELAY, 17'd65535, 1'b0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'h123456, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'hFEDCBA, 1'b0, '0},
        // zero step: fade stays parked
        '{ROW_CFG, CFG_FADE_STEP, 17'd0, 1'b0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_TARGET_DELAY, 17'd3, 1'b0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h0F0F0F, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'hF0F0F0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h7FFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_FADE_STEP, 17'd65536, 1'b0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_TARGET_DELAY, 17'd2, 1'b0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'h800000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'h000100, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b0, 24'h3C3C3C, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 1'b1, 24'hC3C3C3, 1'b0, '0},
        '{ROW_CFG, CFG_FADE_STEP, 17'd6554, 1'b0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_TARGET_DELAY, 17'd0, 1'b0, '0, 1'b0, '0}
    };

    // ---- main sequence ----
    initial
    begin
        dir_row_t r;
        delay_line_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            r = dir_tab[i];
            if (r.kind == ROW_CFG)
            begin
                settle();
                cfg_write(r.idx, r.val);
            end
            else
                send_sample(r.chan, sample_t'(r.smp), r.chk, sample_t'(r.want));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // mostly short delays so taps land on recent writes
            if ($urandom_range(5) == 0)
                cfg_write(CFG_TARGET_DELAY, CFG_W'($urandom_range(65535)));
            else
                cfg_write(CFG_TARGET_DELAY, CFG_W'($urandom_range(40)));
            if ($urandom_range(3) == 0)
                cfg_write(CFG_FEEDBACK_GAIN, CFG_W'($urandom_range(65535)));
            else
                cfg_write(CFG_FEEDBACK_GAIN, CFG_W'($urandom_range(32768)));
            if ($urandom_range(4) == 0)
                cfg_write(CFG_FADE_STEP, CFG_W'($urandom_range(65536, 131071)));
            else
                cfg_write(CFG_FADE_STEP, CFG_W'($urandom_range(1000, 40000)));
            // output held off while requests keep coming
            if (ph % 5 == 4)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(1'($urandom_range(1)), pick_sample(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (4 * LATENCY) @(posedge clk);
        while (pending_out.size() != 0)
            report_mismatch("missing result", pending_out.pop_front(), '0);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/cfd_pkg.sv
sv/cfd_ram.sv
sv/cfd_fade.sv
sv/crossfading_feedback_delay.sv
sv/cfd_checker.sv
tb/tb_crossfading_feedback_delay.sv
